// ----- src/pcir_pkg.sv -----
// ----------------------------------------------------------------------------
// pcir_pkg
// Shared types, register indexes and saturation helpers for the PID
// controller with integral reset.
// ----------------------------------------------------------------------------
package pcir_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 4'd7;

  // Serial multiplier: 4-bit digits of the multiplier, 8 steps per product
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned N_DIG   = 32 / DIG_W;
  localparam int unsigned DCNT_W  = $clog2(N_DIG);
  localparam int unsigned ACC_W   = 37;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic        [30:0] step_time;
    logic        [30:0] step_rate;
    logic signed [31:0] out_max;
    logic signed [31:0] out_min;
    logic signed [31:0] integral_limit;
  } pcir_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_M_INT,
    ST_M_DER,
    ST_M_GI,
    ST_M_GP,
    ST_M_GD,
    ST_SUM,
    ST_WB
  } pcir_state_t;

  // Saturate a 48-bit floored product to signed 32 bits
  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic fits;
    fits = (&v[47:31]) || !(|v[47:31]);
    if (fits) return v[31:0];
    else if (v[47]) return S32_MIN;
    else return S32_MAX;
  endfunction

  // Saturate a 33-bit sum or difference to signed 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] == v[31]) return v[31:0];
    else if (v[32]) return S32_MIN;
    else return S32_MAX;
  endfunction

endpackage

// ----- src/pcir_mul.sv -----
// ----------------------------------------------------------------------------
// pcir_mul
// Digit-serial signed 32x32 multiplier, one 4-bit digit of the multiplier
// per cycle, giving the exact product floored by 2^16.
// ----------------------------------------------------------------------------
module pcir_mul
  import pcir_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic               done,
  output logic signed [47:0] q_floor
);

  logic                     busy_r,  busy_nxt;
  logic                     done_r,  done_nxt;
  logic [DCNT_W-1:0]        cnt_r,   cnt_nxt;
  logic signed [31:0]       a_r,     a_nxt;
  logic signed [ACC_W-1:0]  hi_r,    hi_nxt;
  logic [31:0]              lo_r,    lo_nxt;

  logic                     last_dig;
  logic signed [DIG_W:0]    dig;
  logic signed [ACC_W-1:0]  pp;
  logic signed [ACC_W:0]    acc_sum;

  // Low digits are unsigned, the top digit carries the sign of op_b
  assign last_dig = (cnt_r == DCNT_W'(N_DIG - 1));
  assign dig      = {lo_r[DIG_W-1] & last_dig, lo_r[DIG_W-1:0]};
  assign pp       = a_r * dig;
  assign acc_sum  = (ACC_W+1)'(hi_r) + (ACC_W+1)'(pp);

  // Load operands on start, otherwise add one partial product and shift
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = op_a;
      hi_nxt   = '0;
      lo_nxt   = op_b;
    end else if (busy_r) begin
      hi_nxt  = ACC_W'(acc_sum >>> DIG_W);
      lo_nxt  = {acc_sum[DIG_W-1:0], lo_r[31:DIG_W]};
      cnt_nxt = cnt_r + 1'b1;
      if (last_dig) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r  <= a_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  // Product is {hi[31:0], lo}; drop the 16 fraction bits (floor)
  assign done    = done_r;
  assign q_floor = {hi_r[31:0], lo_r[31:16]};

endmodule

// ----- src/pcir_regs.sv -----
// ----------------------------------------------------------------------------
// pcir_regs
// Configuration register file: gains, dt and 1/dt, clamp range and the
// integral clear threshold.
// ----------------------------------------------------------------------------
module pcir_regs
  import pcir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output pcir_cfg_t             cfg
);

  pcir_cfg_t cfg_r, cfg_nxt;

  // Decode the write; indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wen) begin
      unique case (cfg_index)
        CFG_GAIN_P:    cfg_nxt.gain_p         = cfg_wdata;
        CFG_GAIN_I:    cfg_nxt.gain_i         = cfg_wdata;
        CFG_GAIN_D:    cfg_nxt.gain_d         = cfg_wdata;
        CFG_STEP_TIME: cfg_nxt.step_time      = cfg_wdata[30:0];
        CFG_STEP_RATE: cfg_nxt.step_rate      = cfg_wdata[30:0];
        CFG_OUT_MAX:   cfg_nxt.out_max        = cfg_wdata;
        CFG_OUT_MIN:   cfg_nxt.out_min        = cfg_wdata;
        CFG_INT_LIMIT: cfg_nxt.integral_limit = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.step_time      <= 31'd65536;
      cfg_r.step_rate      <= 31'd65536;
      cfg_r.out_max        <= S32_MAX;
      cfg_r.out_min        <= S32_MIN;
      cfg_r.integral_limit <= S32_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- src/pid_controller_with_integral_reset_top.sv -----
// ----------------------------------------------------------------------------
// pid_controller_with_integral_reset_top
// PID controller with integral reset, signed Q16.16, one shared
// digit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer carries target and measured; one drive value comes
//           back on out_* for every input transfer, in order.
//   cfg_* : write gains, dt, 1/dt, clamp range and clear threshold while
//           the block is idle; a write takes effect on the next edge.
// Sequence:
//   Five products run in turn on one multiplier that takes one 4-bit digit
//   per cycle, in 8 steps per product. After the error and sum states,
//   write-back loads the output register and sets out_tvalid, and in_tready
//   returns in that same cycle, so the block takes one item at a time and
//   accepts the next only once the last one is through.
// Stall:
//   The result sits in an output register; the next item is accepted and
//   computed while it waits. A finished second result holds in the block
//   until the output register is taken.
// Reset:
//   rst_n low clears the integral and the previous error to zero, empties
//   the output register and returns the registers to their defaults.
// ----------------------------------------------------------------------------
module pid_controller_with_integral_reset_top
  import pcir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: [31:0] target, [63:32] measured
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,
  // out_tdata: [31:0] drive
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  pcir_cfg_t          cfg;
  pcir_state_t        state_r, state_nxt;

  logic signed [31:0] err_r, integral_r, prev_err_r, deriv_r;
  logic signed [31:0] term_p_r, term_i_r, term_d_r, drive_r;
  logic signed [31:0] out_data_r;
  logic               out_valid_r;

  logic               mul_start, mul_done;
  logic signed [31:0] mul_a, mul_b;
  logic signed [47:0] mul_q;
  logic signed [31:0] mul_sat;
  logic signed [31:0] diff;
  logic               clear_int;
  logic               load_out;
  logic               in_xfer;
  logic signed [33:0] sum_all;
  logic signed [33:0] sum_hi_clamped;
  logic signed [31:0] drive_nxt;

  pcir_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcir_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .q_floor (mul_q)
  );

  assign in_xfer   = in_tvalid && in_tready;
  assign mul_sat   = sat48(mul_q);
  assign diff      = sat33(33'(err_r) - 33'(prev_err_r));
  assign clear_int = mul_q > 48'(cfg.integral_limit);

  // Add the three terms exactly, then clamp high and then low
  assign sum_all        = 34'(term_p_r) + 34'(term_i_r) + 34'(term_d_r);
  assign sum_hi_clamped = (sum_all > 34'(cfg.out_max)) ? 34'(cfg.out_max) : sum_all;
  assign drive_nxt      = (sum_hi_clamped < 34'(cfg.out_min)) ? cfg.out_min
                                                              : sum_hi_clamped[31:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_M_INT;
      ST_M_INT: if (mul_done) state_nxt = ST_M_DER;
      ST_M_DER: if (mul_done) state_nxt = ST_M_GI;
      ST_M_GI:  if (mul_done) state_nxt = ST_M_GP;
      ST_M_GP:  if (mul_done) state_nxt = ST_M_GD;
      ST_M_GD:  if (mul_done) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_WB;
      ST_WB:    if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: handshake, multiplier launch and operand selection
  always_comb begin
    in_tready = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_ERR: begin
        mul_start = 1'b1;
        mul_a     = err_r;
        mul_b     = {1'b0, cfg.step_time};
      end
      ST_M_INT: begin
        mul_start = mul_done;
        mul_a     = diff;
        mul_b     = {1'b0, cfg.step_rate};
      end
      ST_M_DER: begin
        mul_start = mul_done;
        mul_a     = cfg.gain_i;
        mul_b     = integral_r;
      end
      ST_M_GI: begin
        mul_start = mul_done;
        mul_a     = cfg.gain_p;
        mul_b     = err_r;
      end
      ST_M_GP: begin
        mul_start = mul_done;
        mul_a     = cfg.gain_d;
        mul_b     = deriv_r;
      end
      ST_M_GD:  ;
      ST_SUM:   ;
      ST_WB:    load_out = !out_valid_r || out_tready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      integral_r  <= '0;
      prev_err_r  <= '0;
    end else begin
      state_r <= state_nxt;

      // Hold the result until the transfer, refill from write-back
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      // Integral: add floored error*dt, clear when gain_i*I passes the limit
      if (state_r == ST_M_INT && mul_done) begin
        integral_r <= sat33(33'(integral_r) + 33'(mul_sat));
      end
      if (state_r == ST_M_GI && mul_done && clear_int) begin
        integral_r <= '0;
      end

      if (load_out) prev_err_r <= err_r;
    end

    // Capture the error on the input transfer
    if (in_xfer) begin
      err_r <= sat33(33'($signed(in_tdata[31:0])) - 33'($signed(in_tdata[63:32])));
    end

    if (state_r == ST_M_DER && mul_done) deriv_r <= mul_sat;
    if (state_r == ST_M_GI && mul_done) term_i_r <= clear_int ? '0 : mul_sat;
    if (state_r == ST_M_GP && mul_done) term_p_r <= mul_sat;
    if (state_r == ST_M_GD && mul_done) term_d_r <= mul_sat;
    if (state_r == ST_SUM) drive_r <= drive_nxt;
    if (load_out) out_data_r <= drive_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- src/pcir_checker.sv -----
// ----------------------------------------------------------------------------
// pcir_checker
// Port-level checks for the PID controller, bound to the top level.
// ----------------------------------------------------------------------------
module pcir_checker
  import pcir_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [31:0]           out_tdata
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("drive changed or dropped while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

  // One item at a time: busy after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second input taken while an item is in progress");

  // A new result appears only as the block frees up for the next item
  a_new_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !$past(out_tvalid) && $past(rst_n) |-> in_tready)
    else $error("result delivered while still busy");

endmodule

bind pid_controller_with_integral_reset_top pcir_checker u_pcir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PID controller with integral reset. A short
// list of directed steps runs first, then extreme and random settings with
// slowly drifting loop samples and noise. An in-bench model of the control
// law predicts every drive value, and a monitor compares each output
// transfer against the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import pcir_pkg::*;

  localparam int          HOLD_CYCLES = 500;
  localparam int          TAIL_CYCLES = 100;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_ITEMS = 116;
  localparam int          BACKLOG_PHASE = 3;
  localparam int          LIMIT_NS    = 5_000_000;
  localparam logic [31:0] Q_ONE       = 32'h0001_0000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          wdata;
    logic [31:0]          tgt;
    logic [31:0]          meas;
    bit                   typed;
    logic [31:0]          drive;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [63:0]           in_tdata;   // [31:0] target, [63:32] measured
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;  // [31:0] drive
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Control-law model: registers and loop state
  longint kp = 0, ki = 0, kd = 0;
  longint dt = 65536, inv_dt = 65536;
  longint drive_hi = 64'sd2147483647, drive_lo = -64'sd2147483648;
  longint clear_lim = 64'sd2147483647;
  longint integ = 0, last_err = 0;

  logic [31:0] drive_expected[$];
  plan_row_t   plan[$];

  int  errors = 0, items_in = 0, results_seen = 0;
  int  clears = 0, clamps = 0, reg_writes = 0;
  int  burst_left = 0;
  bit  steady_send = 1'b0;
  bit  backlog_req = 1'b0;
  bit  backlog_served = 1'b0;

  pid_controller_with_integral_reset_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Exact Q16.16 product, floored
  function automatic longint q_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_GAIN_P:    kp        = longint'(signed'(data));
      CFG_GAIN_I:    ki        = longint'(signed'(data));
      CFG_GAIN_D:    kd        = longint'(signed'(data));
      CFG_STEP_TIME: dt        = longint'({1'b0, data[30:0]});
      CFG_STEP_RATE: inv_dt    = longint'({1'b0, data[30:0]});
      CFG_OUT_MAX:   drive_hi  = longint'(signed'(data));
      CFG_OUT_MIN:   drive_lo  = longint'(signed'(data));
      CFG_INT_LIMIT: clear_lim = longint'(signed'(data));
      default: ;
    endcase
  endfunction

  // Advance the loop state by one sample and return the clamped drive
  function automatic logic [31:0] next_drive(input logic [31:0] tgt, input logic [31:0] meas);
    longint err, deriv, total;
    err   = clip32(longint'(signed'(tgt)) - longint'(signed'(meas)));
    integ = clip32(integ + clip32(q_mul(err, dt)));
    deriv = clip32(q_mul(clip32(err - last_err), inv_dt));
    // clear on the positive side only, against the unsaturated product
    if (q_mul(ki, integ) > clear_lim) begin
      integ = 0;
      clears++;
    end
    total = clip32(q_mul(kp, err)) + clip32(q_mul(ki, integ)) + clip32(q_mul(kd, deriv));
    if (total > drive_hi || total < drive_lo) clamps++;
    if (total > drive_hi) total = drive_hi;
    if (total < drive_lo) total = drive_lo;
    last_err = err;
    return total[31:0];
  endfunction

  function automatic void plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    plan_row_t r;
    r.is_write = 1'b1;
    r.idx      = idx;
    r.wdata    = data;
    r.tgt      = '0;
    r.meas     = '0;
    r.typed    = 1'b0;
    r.drive    = '0;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void plan_item(input logic [31:0] tgt, input logic [31:0] meas,
                                    input bit typed, input logic [31:0] drive);
    plan_row_t r;
    r.is_write = 1'b0;
    r.idx      = '0;
    r.wdata    = '0;
    r.tgt      = tgt;
    r.meas     = meas;
    r.typed    = typed;
    r.drive    = drive;
    plan.insert(plan.size(), r);
  endfunction

  function automatic logic [31:0] pick_extreme();
    case ($urandom_range(4, 0))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return S32_MAX;
      3:       return S32_MIN;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_reg(input logic [CFG_IDX_W-1:0] idx);
    int unsigned roll;
    roll = $urandom_range(9, 0);
    if (roll == 0) return pick_extreme();
    if (roll == 1) return $urandom;
    case (idx)
      CFG_STEP_TIME: return $urandom_range(32'h0002_0000, 32'h0000_0100);
      CFG_STEP_RATE: return $urandom_range(32'h0010_0000, 32'h0000_8000);
      CFG_OUT_MAX:   return $urandom_range(32'h0100_0000, 0);
      CFG_OUT_MIN:   return -$urandom_range(32'h0100_0000, 0);
      CFG_INT_LIMIT: return $urandom_range(32'h0080_0000, 0) - 32'h0010_0000;
      // gains within +-4.0
      default:       return $urandom_range(32'h0008_0000, 0) - 32'h0004_0000;
    endcase
  endfunction

  // Fixed extremes for the first two random phases, random settings after
  function automatic logic [31:0] phase_reg(input int ph, input logic [CFG_IDX_W-1:0] idx);
    if (ph == 0) begin
      case (idx)
        CFG_OUT_MIN: return S32_MIN;
        default:     return S32_MAX;
      endcase
    end
    if (ph == 1) begin
      case (idx) inside
        CFG_STEP_TIME, CFG_STEP_RATE: return 32'h0000_0000;
        CFG_OUT_MAX:                  return S32_MAX;
        default:                      return S32_MIN;
      endcase
    end
    return pick_reg(idx);
  endfunction

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(3, 0))
      0:       return pick_extreme();
      1:       return $urandom;
      default: return $urandom_range(32'h0200_0000, 0) - 32'h0100_0000;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    load_reg(idx, data);
    reg_writes++;
  endtask

  task automatic release_cfg();
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Offer one sample in bursts with random gaps; predict on transfer
  task automatic send_sample(input logic [31:0] tgt, input logic [31:0] meas,
                             input bit typed, input logic [31:0] typed_drive);
    int gap;
    logic [31:0] predicted;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(30, 1);
      gap = 0;
      if (!steady_send && $urandom_range(2, 0) != 0) gap = $urandom_range(20, 1);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {meas, tgt};
    do @(posedge clk); while (!in_tready);
    predicted = next_drive(tgt, meas);
    drive_expected.insert(drive_expected.size(), typed ? typed_drive : predicted);
    items_in++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (drive_expected.size() != 0) @(posedge clk);
  endtask

  // Receiver: one long hold-off on request, otherwise a changing stall pattern
  initial begin : receiver
    int mode, left, tick;
    logic [15:0] mask;
    mode = 0;
    left = 0;
    tick = 0;
    mask = '1;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (backlog_req && !backlog_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        backlog_served = 1'b1;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(3, 0);
          left = $urandom_range(200, 20);
          mask = 16'($urandom) | 16'h0001;
        end
        left--;
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= mask[tick % 16];
          2:       out_tready <= ($urandom_range(1, 0) == 1);
          default: out_tready <= ($urandom_range(7, 0) == 0);
        endcase
        tick++;
      end
    end
  end

  // Compare each drive transfer with the oldest prediction
  always @(posedge clk) begin : drive_check
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (drive_expected.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: drive %h arrived with nothing expected", $time, out_tdata);
      end else begin
        want = drive_expected.pop_front();
        if (out_tdata !== want) begin
          errors++;
          if (errors <= 40)
            $display("%0t: drive expected %h actual %h", $time, want, out_tdata);
        end
      end
    end
  end

  initial begin : stimulus
    logic signed [31:0] set_pt, track;
    int run_left;
    bit writing;
    run_left  = 0;
    writing   = 1'b0;
    set_pt    = '0;
    track     = '0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    // Gains at zero after reset: drive is zero even at the input extremes
    plan_item(S32_MAX, S32_MIN, 1'b1, 32'h0000_0000);
    plan_item(S32_MIN, S32_MAX, 1'b1, 32'h0000_0000);
    plan_item(32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000);
    // Pure proportional, unit gain; the error saturates at both ends
    plan_write(CFG_GAIN_P, Q_ONE);
    plan_item(32'h0005_0000, 32'h0002_0000, 1'b1, 32'h0003_0000);
    plan_item(S32_MAX, S32_MIN, 1'b1, S32_MAX);
    plan_item(S32_MIN, S32_MAX, 1'b1, S32_MIN);
    // Clamp to +-1.0
    plan_write(CFG_OUT_MAX, 32'h0001_0000);
    plan_write(CFG_OUT_MIN, 32'hFFFF_0000);
    plan_item(32'h0005_0000, 32'h0000_0000, 1'b1, 32'h0001_0000);
    plan_item(32'hFFFB_0000, 32'h0000_0000, 1'b1, 32'hFFFF_0000);
    plan_item(32'h0000_8000, 32'h0000_0000, 1'b1, 32'h0000_8000);
    // Inverted clamp range: drive sticks at the lower bound
    plan_write(CFG_OUT_MIN, 32'h0002_0000);
    plan_item(32'h0005_0000, 32'h0000_0000, 1'b1, 32'h0002_0000);
    plan_item(S32_MIN, 32'h0000_0000, 1'b1, 32'h0002_0000);
    // Integral builds to the threshold and clears; bit 31 of dt is dropped
    plan_write(CFG_OUT_MAX, S32_MAX);
    plan_write(CFG_OUT_MIN, S32_MIN);
    plan_write(CFG_GAIN_I, Q_ONE);
    plan_write(CFG_INT_LIMIT, 32'h000A_0000);
    plan_write(CFG_STEP_TIME, 32'h8001_0000);
    plan_item(32'h0004_0000, 32'h0000_0000, 1'b0, '0);
    plan_item(32'h0004_0000, 32'h0000_0000, 1'b0, '0);
    plan_item(32'h0004_0000, 32'h0000_0000, 1'b0, '0);
    plan_item(32'h0004_0000, 32'h0000_0000, 1'b0, '0);
    // Negative threshold, zero dt, derivative only through 1/dt
    plan_write(CFG_INT_LIMIT, S32_MIN);
    plan_write(CFG_STEP_TIME, 32'h0000_0000);
    plan_write(CFG_GAIN_D, 32'h0002_0000);
    plan_write(CFG_STEP_RATE, 32'h0000_4000);
    plan_item(32'h0003_0000, 32'h0001_0000, 1'b0, '0);
    plan_item(32'hFFFD_0000, 32'h0001_0000, 1'b0, '0);
    plan_write(CFG_STEP_RATE, 32'h0000_0000);
    plan_item(32'h0007_0000, 32'h0000_0000, 1'b0, '0);
    // Writes past the last register are ignored
    plan_write(REG_UNUSED_LO, 32'hFFFF_FFFF);
    plan_write(REG_UNUSED_HI, 32'h1234_5678);
    plan_item(32'h0001_0000, 32'hFFFF_0000, 1'b0, '0);
    // All registers at their extremes
    plan_write(CFG_GAIN_P, S32_MIN);
    plan_write(CFG_GAIN_I, S32_MAX);
    plan_write(CFG_GAIN_D, S32_MIN);
    plan_write(CFG_STEP_TIME, 32'h7FFF_FFFF);
    plan_write(CFG_STEP_RATE, 32'hFFFF_FFFF);
    plan_write(CFG_INT_LIMIT, S32_MAX);
    plan_item(S32_MAX, S32_MIN, 1'b0, '0);
    plan_item(S32_MIN, S32_MAX, 1'b0, '0);
    plan_item(32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '0);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed steps; write registers only once drained
    foreach (plan[n]) begin
      if (plan[n].is_write) begin
        if (!writing) drain_results();
        writing = 1'b1;
        write_reg(plan[n].idx, plan[n].wdata);
      end else begin
        if (writing) release_cfg();
        writing = 1'b0;
        send_sample(plan[n].tgt, plan[n].meas, plan[n].typed, plan[n].drive);
      end
    end

    // Random phases: new settings, then drifting loop runs mixed with noise
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      for (int r = CFG_GAIN_P; r <= CFG_INT_LIMIT; r++)
        write_reg(CFG_IDX_W'(r), phase_reg(ph, CFG_IDX_W'(r)));
      write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)), $urandom);
      release_cfg();
      steady_send = ($urandom_range(3, 0) == 0);
      if (ph == BACKLOG_PHASE) backlog_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(9, 0) < 3) begin
          send_sample(pick_sample(), pick_sample(), 1'b0, '0);
        end else begin
          if (run_left == 0) begin
            set_pt   = $urandom_range(32'h0200_0000, 0) - 32'h0100_0000;
            track    = $urandom_range(32'h0200_0000, 0) - 32'h0100_0000;
            run_left = $urandom_range(40, 5);
          end
          run_left--;
          // pull the measurement toward the setpoint with some jitter
          track = track + ((set_pt - track) >>> 3)
                  + signed'($urandom_range(32'h0000_8000, 0) - 32'h0000_4000);
          send_sample(set_pt, track, 1'b0, '0);
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d samples in, %0d drive values out, %0d register writes",
             items_in, results_seen, reg_writes);
    $display("model saw %0d integral clears and %0d clamped drives", clears, clamps);
    if (errors == 0) begin
      $display("pid_controller_with_integral_reset_top: match");
    end else begin
      $display("pid_controller_with_integral_reset_top: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("pid_controller_with_integral_reset_top: mismatch");
    $finish;
  end

endmodule
